[sv/btl_pkg.sv]
// Shared types, constants and helper functions for the serial terminal link.
// No dependencies; every other file in the project but btl_if uses this package.
`default_nettype none

package btl_pkg;

	typedef enum logic [1:0] {
		ACT_TICK = 2'd0,
		ACT_QCHG = 2'd1,
		ACT_HOST = 2'd2,
		ACT_CTRL = 2'd3
	} action_t;

	typedef enum logic [2:0] {
		REG_EIGHT_DATA_BITS    = 3'd0,
		REG_PARITY_ENABLE      = 3'd1,
		REG_PARITY_EVEN        = 3'd2,
		REG_LINE_INVERT        = 3'd3,
		REG_FLAG_INVERT        = 3'd4,
		REG_SEND_BIT_PERIOD    = 3'd5,
		REG_RECEIVE_BIT_PERIOD = 3'd6
	} reg_idx_t;

	localparam logic [7:0]  CTRL_DISABLE      = 8'h40;
	localparam logic [7:0]  CTRL_ENABLE       = 8'h80;
	localparam logic [15:0] RESET_BIT_PERIOD  = 16'd651;
	localparam logic [7:0]  PARITY_ERROR_BYTE = 8'd2;

	typedef struct packed {
		logic        eight_data_bits;
		logic        parity_enable;
		logic        parity_even;
		logic        line_invert;
		logic        flag_invert;
		logic [15:0] send_bit_period;
		logic [15:0] receive_bit_period;
	} cfg_t;

	typedef struct packed {
		logic       fire;
		action_t    action;
		logic [7:0] data;
		logic       q_level;
	} step_t;

	// zero period counts as one
	function automatic logic [15:0] period_of(input logic [15:0] p);
		period_of = (p == 16'd0) ? 16'd1 : p;
	endfunction

	function automatic logic calc_parity(input logic [7:0] v, input logic eight,
			input logic even);
		calc_parity = (^(v & {eight, 7'h7f})) ^ ~even;
	endfunction

endpackage

`default_nettype wire

[sv/btl_if.sv]
// Handshake channels of the serial terminal link: items in, results out, config writes.
// No dependencies.
`default_nettype none

interface btl_item_if;
	logic       valid;
	logic       ready;
	logic [1:0] action;
	logic [7:0] data;
	logic       q_level;
	modport source (output valid, action, data, q_level, input ready);
	modport sink (input valid, action, data, q_level, output ready);
endinterface

interface btl_result_if;
	logic       valid;
	logic       ready;
	logic       flag_level;
	logic [6:0] received_byte;
	logic       received_valid;
	logic       send_pending;
	modport source (output valid, flag_level, received_byte, received_valid, send_pending,
		input ready);
	modport sink (input valid, flag_level, received_byte, received_valid, send_pending,
		output ready);
endinterface

interface btl_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [15:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

[sv/btl_cfg.sv]
// Configuration register file of the serial terminal link.
// Depends on btl_pkg and btl_cfg_if.
`default_nettype none

module btl_cfg (
	input  wire logic    clk,
	input  wire logic    arst_n,
	btl_cfg_if.sink      cfg,
	output btl_pkg::cfg_t regs
);

	btl_pkg::cfg_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.eight_data_bits    <= 1'b1;
			regs_q.parity_enable      <= 1'b0;
			regs_q.parity_even        <= 1'b1;
			regs_q.line_invert        <= 1'b1;
			regs_q.flag_invert        <= 1'b1;
			regs_q.send_bit_period    <= btl_pkg::RESET_BIT_PERIOD;
			regs_q.receive_bit_period <= btl_pkg::RESET_BIT_PERIOD;
		end else if (cfg.valid) begin
			unique case (btl_pkg::reg_idx_t'(cfg.index))
				btl_pkg::REG_EIGHT_DATA_BITS:    regs_q.eight_data_bits    <= cfg.data[0];
				btl_pkg::REG_PARITY_ENABLE:      regs_q.parity_enable      <= cfg.data[0];
				btl_pkg::REG_PARITY_EVEN:        regs_q.parity_even        <= cfg.data[0];
				btl_pkg::REG_LINE_INVERT:        regs_q.line_invert        <= cfg.data[0];
				btl_pkg::REG_FLAG_INVERT:        regs_q.flag_invert        <= cfg.data[0];
				btl_pkg::REG_SEND_BIT_PERIOD:    regs_q.send_bit_period    <= cfg.data;
				btl_pkg::REG_RECEIVE_BIT_PERIOD: regs_q.receive_bit_period <= cfg.data;
				default: ;
			endcase
		end
	end

endmodule

`default_nettype wire

[sv/btl_tx.sv]
// Transmit framer: host byte to start, data, parity and stop bits on the flag line.
// Also holds the link enable set by control writes. Depends on btl_pkg.
`default_nettype none

module btl_tx (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  btl_pkg::step_t     step,
	input  btl_pkg::cfg_t      regs,
	output logic               serial_bit,
	output logic               pending
);

	logic [7:0]  shift_q, shift_d;
	logic        busy_q, busy_d;
	logic [15:0] cnt_q, cnt_d;
	logic [3:0]  bits_q, bits_d;
	logic        par_q, par_d;
	logic        pend_q, pend_d;
	logic        ser_q, ser_d;
	logic        en_q, en_d;
	logic [15:0] period;

	assign period = btl_pkg::period_of(regs.send_bit_period);

	always_comb begin
		shift_d = shift_q;
		busy_d  = busy_q;
		cnt_d   = cnt_q;
		bits_d  = bits_q;
		par_d   = par_q;
		pend_d  = pend_q;
		ser_d   = ser_q;
		en_d    = en_q;
		case (step.action)
			btl_pkg::ACT_TICK: begin
				if (busy_q) begin
					cnt_d = cnt_q - 16'd1;
					if (cnt_q == 16'd1) begin
						ser_d   = shift_q[0];
						shift_d = {1'b1, shift_q[7:1]};
						cnt_d   = period;
						if (regs.parity_enable && bits_q == 4'd3) ser_d = par_q;
						if (bits_q == 4'd2) ser_d = 1'b1;
						bits_d = bits_q - 4'd1;
						if (bits_d == 4'd0) begin
							shift_d = 8'd0;
							pend_d  = 1'b0;
							busy_d  = 1'b0;
						end
					end
				end else if (pend_q && en_q) begin
					ser_d  = 1'b0;
					par_d  = btl_pkg::calc_parity(shift_q, regs.eight_data_bits,
						regs.parity_even);
					cnt_d  = period;
					busy_d = 1'b1;
					bits_d = 4'd9 + {3'd0, regs.eight_data_bits} + {3'd0, regs.parity_enable};
				end
			end
			btl_pkg::ACT_HOST: begin
				if (!busy_q) begin
					shift_d = step.data;
					pend_d  = 1'b1;
				end
			end
			btl_pkg::ACT_CTRL: begin
				if (step.data == btl_pkg::CTRL_DISABLE) en_d = 1'b0;
				if (step.data == btl_pkg::CTRL_ENABLE) en_d = 1'b1;
			end
			default: ;
		endcase
	end

	assign serial_bit = ser_d;
	assign pending    = pend_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_q <= 8'd0;
			busy_q  <= 1'b0;
			cnt_q   <= 16'd0;
			bits_q  <= 4'd0;
			par_q   <= 1'b0;
			pend_q  <= 1'b0;
			ser_q   <= 1'b1;
			en_q    <= 1'b1;
		end else if (step.fire) begin
			shift_q <= shift_d;
			busy_q  <= busy_d;
			cnt_q   <= cnt_d;
			bits_q  <= bits_d;
			par_q   <= par_d;
			pend_q  <= pend_d;
			ser_q   <= ser_d;
			en_q    <= en_d;
		end
	end

endmodule

`default_nettype wire

[sv/btl_rx.sv]
// Receive sampler: Q line edge starts a frame, bits sampled mid-period and shifted in.
// Depends on btl_pkg.
`default_nettype none

module btl_rx (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  btl_pkg::step_t step,
	input  btl_pkg::cfg_t  regs,
	output logic           rx_valid,
	output logic [6:0]     rx_byte
);

	logic        busy_q, busy_d;
	logic [16:0] cnt_q, cnt_d, cnt_m;
	logic [3:0]  bits_q, bits_d;
	logic [7:0]  shift_q, shift_d, sh;
	logic [15:0] period;
	logic        bit_in;

	assign period = btl_pkg::period_of(regs.receive_bit_period);

	always_comb begin
		busy_d   = busy_q;
		cnt_d    = cnt_q;
		bits_d   = bits_q;
		shift_d  = shift_q;
		rx_valid = 1'b0;
		rx_byte  = 7'd0;
		cnt_m    = cnt_q - 17'd1;
		bit_in   = ~(step.q_level ^ regs.line_invert);
		sh       = shift_q;
		case (step.action)
			btl_pkg::ACT_TICK: begin
				if (busy_q) begin
					cnt_d = cnt_m;
					if (cnt_m == 17'd0) begin
						if (regs.parity_enable) begin
							if (bits_q > 4'd2) sh = {bit_in, sh[7:1]};
							if (bits_q == 4'd2) begin
								if (!regs.eight_data_bits) sh = {1'b0, sh[7:1]};
								if (btl_pkg::calc_parity(sh, regs.eight_data_bits,
										regs.parity_even) != bit_in)
									sh = btl_pkg::PARITY_ERROR_BYTE;
							end
						end else begin
							if (bits_q > 4'd1) sh = {bit_in, sh[7:1]};
							if (bits_q == 4'd1 && !regs.eight_data_bits) sh = {1'b0, sh[7:1]};
						end
						cnt_d  = {1'b0, period};
						bits_d = bits_q - 4'd1;
						if (bits_d == 4'd0) begin
							busy_d   = 1'b0;
							sh       = {1'b0, sh[6:0]};
							rx_valid = 1'b1;
							rx_byte  = sh[6:0];
						end
						shift_d = sh;
					end
				end
			end
			btl_pkg::ACT_QCHG: begin
				if (!busy_q && (step.data[0] ^ regs.line_invert)) begin
					cnt_d   = {1'b0, period} + {2'b0, period[15:1]};
					bits_d  = 4'd8 + {3'd0, regs.eight_data_bits} + {3'd0, regs.parity_enable};
					shift_d = 8'd0;
					busy_d  = 1'b1;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			cnt_q   <= 17'd0;
			bits_q  <= 4'd0;
			shift_q <= 8'd0;
		end else if (step.fire) begin
			busy_q  <= busy_d;
			cnt_q   <= cnt_d;
			bits_q  <= bits_d;
			shift_q <= shift_d;
		end
	end

endmodule

`default_nettype wire

[sv/bit_banged_serial_terminal_link.sv]
// Serial terminal link between a host byte stream, a CPU flag pin and the Q line.
// Top level; depends on btl_pkg, btl_if, btl_cfg, btl_tx and btl_rx.
//
// Each accepted item is one action: a tick, a Q line change, a host byte or a
// control write, and gives exactly one result. The block takes one item per
// clock cycle while its results are taken: each item waits in the input
// register, then the framer and sampler update their state and load the
// result register. Bit timing is counted in tick items, not clock cycles.
// A full result register that is not taken holds the input side after one more
// item. Configuration writes are always ready and apply from the next item on.
`default_nettype none

module bit_banged_serial_terminal_link (
	input  wire logic    clk,
	input  wire logic    arst_n,
	btl_item_if.sink     item_in,
	btl_result_if.source result_out,
	btl_cfg_if.sink      cfg
);

	btl_pkg::cfg_t   regs;
	btl_pkg::step_t  step;

	logic       valid_s1;
	logic [1:0] action_s1;
	logic [7:0] data_s1;
	logic       q_s1;

	logic       valid_s2;
	logic       flag_s2;
	logic [6:0] byte_s2;
	logic       rxv_s2;
	logic       pend_s2;

	logic       adv;
	logic       serial_bit;
	logic       pending;
	logic       rx_valid;
	logic [6:0] rx_byte;

	assign adv           = valid_s1 && (!valid_s2 || result_out.ready);
	assign item_in.ready = !valid_s1 || adv;

	assign step.fire    = adv;
	assign step.action  = btl_pkg::action_t'(action_s1);
	assign step.data    = data_s1;
	assign step.q_level = q_s1;

	btl_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	btl_tx u_tx (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (step),
		.regs       (regs),
		.serial_bit (serial_bit),
		.pending    (pending)
	);

	btl_rx u_rx (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (step),
		.regs     (regs),
		.rx_valid (rx_valid),
		.rx_byte  (rx_byte)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= (item_in.valid && item_in.ready) || (valid_s1 && !adv);
			valid_s2 <= adv || (valid_s2 && !result_out.ready);
		end
	end

	always_ff @(posedge clk) begin
		if (item_in.valid && item_in.ready) begin
			action_s1 <= item_in.action;
			data_s1   <= item_in.data;
			q_s1      <= item_in.q_level;
		end
		if (adv) begin
			flag_s2 <= serial_bit ^ regs.flag_invert;
			byte_s2 <= rx_byte;
			rxv_s2  <= rx_valid;
			pend_s2 <= pending;
		end
	end

	assign result_out.valid          = valid_s2;
	assign result_out.flag_level     = flag_s2;
	assign result_out.received_byte  = byte_s2;
	assign result_out.received_valid = rxv_s2;
	assign result_out.send_pending   = pend_s2;

endmodule

`default_nettype wire

[tb/btl_link_monitor.sv]
`timescale 1ns / 1ps
// Checker for the serial terminal link: tracks register writes, predicts the pin
// state for every accepted item and compares it with each accepted result.
// Depends on btl_pkg and the channel interfaces in btl_if.
module btl_link_monitor (
	input  logic  clk,
	input  logic  arst_n,
	btl_item_if   items,
	btl_result_if results,
	btl_cfg_if    regs,
	output int    errors,
	output int    outstanding
);
	import btl_pkg::*;

	typedef struct packed {
		logic       flag;
		logic [6:0] rx_val;
		logic       rx_done;
		logic       busy;
	} pin_state_t;

	pin_state_t due_pins[$];

	logic        c_eight, c_par_en, c_even, c_linv, c_finv;
	logic [15:0] c_sp, c_rp;

	logic [7:0] snd_shift, rcv_shift;
	logic [3:0] snd_left, rcv_left;
	logic       snd_par, pending, ser_bit, enabled;
	int         snd_cnt, rcv_cnt;

	initial begin
		errors = 0;
		outstanding = 0;
	end

	function automatic int ticks_per_bit(logic [15:0] p);
		return (p == 16'd0) ? 1 : int'(p);
	endfunction

	function automatic logic frame_parity(logic [7:0] v);
		logic ones;
		ones = c_eight ? ^v : ^v[6:0];
		return c_even ? ones : ~ones;
	endfunction

	task automatic report(string what, int got, int want);
		errors = errors + 1;
		$display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
	endtask

	task automatic reset_link();
		c_eight = 1'b1;
		c_par_en = 1'b0;
		c_even = 1'b1;
		c_linv = 1'b1;
		c_finv = 1'b1;
		c_sp = RESET_BIT_PERIOD;
		c_rp = RESET_BIT_PERIOD;
		snd_shift = '0;
		snd_cnt = -1;
		snd_left = '0;
		snd_par = 1'b0;
		pending = 1'b0;
		ser_bit = 1'b1;
		enabled = 1'b1;
		rcv_shift = '0;
		rcv_cnt = -1;
		rcv_left = '0;
	endtask

	task automatic apply_reg(logic [2:0] idx, logic [15:0] v);
		case (idx)
			REG_EIGHT_DATA_BITS: c_eight = v[0];
			REG_PARITY_ENABLE: c_par_en = v[0];
			REG_PARITY_EVEN: c_even = v[0];
			REG_LINE_INVERT: c_linv = v[0];
			REG_FLAG_INVERT: c_finv = v[0];
			REG_SEND_BIT_PERIOD: c_sp = v;
			REG_RECEIVE_BIT_PERIOD: c_rp = v;
			default: ;
		endcase
	endtask

	task automatic advance_link(action_t act, logic [7:0] d, logic q, output pin_state_t o);
		int   r;
		logic smp;
		logic done;
		done = 1'b0;
		case (act)
			ACT_TICK: begin
				if (snd_cnt > 0) begin
					snd_cnt = snd_cnt - 1;
					if (snd_cnt <= 0) begin
						ser_bit = snd_shift[0];
						snd_shift = {1'b1, snd_shift[7:1]};
						snd_cnt = ticks_per_bit(c_sp);
						if (c_par_en && snd_left == 4'd3) ser_bit = snd_par;
						if (snd_left == 4'd2) ser_bit = 1'b1;
						snd_left = snd_left - 4'd1;
						if (snd_left == 4'd0) begin
							snd_shift = '0;
							pending = 1'b0;
							snd_cnt = -1;
						end
					end
				end else if (pending && enabled) begin
					ser_bit = 1'b0;
					snd_par = frame_parity(snd_shift);
					snd_cnt = ticks_per_bit(c_sp);
					snd_left = (c_eight ? 4'd10 : 4'd9) + (c_par_en ? 4'd1 : 4'd0);
				end
				if (rcv_cnt >= 0) begin
					rcv_cnt = rcv_cnt - 1;
					if (rcv_cnt <= 0) begin
						smp = ~(q ^ c_linv);
						if (c_par_en) begin
							if (rcv_left > 4'd2) rcv_shift = {smp, rcv_shift[7:1]};
							if (rcv_left == 4'd2) begin
								if (!c_eight) rcv_shift = rcv_shift >> 1;
								if (frame_parity(rcv_shift) != smp) rcv_shift = PARITY_ERROR_BYTE;
							end
						end else begin
							if (rcv_left > 4'd1) rcv_shift = {smp, rcv_shift[7:1]};
							if (rcv_left == 4'd1 && !c_eight) rcv_shift = rcv_shift >> 1;
						end
						rcv_cnt = ticks_per_bit(c_rp);
						rcv_left = rcv_left - 4'd1;
						if (rcv_left == 4'd0) begin
							rcv_cnt = -1;
							rcv_shift[7] = 1'b0;
							done = 1'b1;
						end
					end
				end
			end
			ACT_QCHG: begin
				if (rcv_cnt < 0 && (d[0] ^ c_linv)) begin
					r = ticks_per_bit(c_rp);
					rcv_cnt = r + r / 2;
					rcv_left = (c_eight ? 4'd9 : 4'd8) + (c_par_en ? 4'd1 : 4'd0);
					rcv_shift = '0;
				end
			end
			ACT_HOST: begin
				if (snd_cnt < 0) begin
					snd_shift = d;
					pending = 1'b1;
				end
			end
			default: begin
				if (d == CTRL_DISABLE) enabled = 1'b0;
				if (d == CTRL_ENABLE) enabled = 1'b1;
			end
		endcase
		o.flag = ser_bit ^ c_finv;
		o.rx_val = done ? rcv_shift[6:0] : 7'd0;
		o.rx_done = done;
		o.busy = pending;
	endtask

	always @(posedge clk) begin
		pin_state_t want;
		pin_state_t got;
		if (!arst_n) begin
			reset_link();
			due_pins.delete();
		end else begin
			if (regs.valid && regs.ready) apply_reg(regs.index, regs.data);
			if (results.valid && results.ready) begin
				got = {results.flag_level, results.received_byte, results.received_valid,
					results.send_pending};
				if (due_pins.size() == 0) begin
					report("result with nothing expected", int'(got), 0);
				end else begin
					want = due_pins.pop_front();
					if (got.flag !== want.flag) report("flag_level", got.flag, want.flag);
					if (got.rx_val !== want.rx_val) report("received_byte", got.rx_val, want.rx_val);
					if (got.rx_done !== want.rx_done)
						report("received_valid", got.rx_done, want.rx_done);
					if (got.busy !== want.busy) report("send_pending", got.busy, want.busy);
				end
			end
			if (items.valid && items.ready) begin
				advance_link(action_t'(items.action), items.data, items.q_level, want);
				due_pins.push_back(want);
			end
		end
		outstanding = due_pins.size();
	end

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps
// Top of the serial terminal link testbench: clock, reset, register settings and
// item stimulus with random idling; checking is done by btl_link_monitor.
// Depends on btl_pkg, btl_if, btl_link_monitor and the link RTL.
module tb;
	import btl_pkg::*;

	localparam logic [2:0] REG_SPARE = 3'd7;
	localparam int STALL_LIMIT = 1000;
	localparam int LAST_SET = 8;

	localparam logic [LAST_SET:0] SET_EIGHT = 9'b1_1001_0101;
	localparam logic [LAST_SET:0] SET_PAR   = 9'b1_1011_0011;
	localparam logic [LAST_SET:0] SET_EVEN  = 9'b0_0110_0101;
	localparam logic [LAST_SET:0] SET_LINV  = 9'b1_1001_0110;
	localparam logic [LAST_SET:0] SET_FINV  = 9'b1_0101_1010;
	localparam logic [15:0] SET_SP [0:LAST_SET] = '{1, 2, 0, 3, 5, 1, 7, 4, 65535};
	localparam logic [15:0] SET_RP [0:LAST_SET] = '{2, 1, 3, 0, 4, 6, 1, 5, 65535};
	localparam logic [12:0] DIRECTED_Q = 13'b1_0110_1001_0011;

	logic clk;
	logic arst_n;
	bit   idle_on;
	int   errors;
	int   outstanding;
	int   quiet;

	logic        t_eight, t_par, t_even, t_linv;
	logic [15:0] t_rp;
	logic        rx_on;
	int          rx_t, rx_len;
	logic [11:0] wave;

	btl_item_if   item_ch ();
	btl_result_if res_ch ();
	btl_cfg_if    cfg_ch ();

	bit_banged_serial_terminal_link u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_in    (item_ch),
		.result_out (res_ch),
		.cfg        (cfg_ch)
	);

	btl_link_monitor u_monitor (
		.clk         (clk),
		.arst_n      (arst_n),
		.items       (item_ch),
		.results     (res_ch),
		.regs        (cfg_ch),
		.errors      (errors),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	task automatic put_item(action_t a, logic [7:0] d, logic q);
		int gap;
		gap = idle_on ? $urandom_range(0, 17) : 0;
		if (gap > 0) begin
			item_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		item_ch.valid <= 1'b1;
		item_ch.action <= a;
		item_ch.data <= d;
		item_ch.q_level <= q;
		@(posedge clk);
		while (!item_ch.ready) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic settle();
		item_ch.valid <= 1'b0;
		while (outstanding != 0) @(negedge clk);
		repeat (6) @(negedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [15:0] val);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= val;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic load_setting(int p);
		logic [15:0] v;
		t_eight = SET_EIGHT[p];
		t_par = SET_PAR[p];
		t_even = SET_EVEN[p];
		t_linv = SET_LINV[p];
		t_rp = SET_RP[p];
		v = 16'($urandom);
		v[0] = t_eight;
		write_reg(REG_EIGHT_DATA_BITS, v);
		v = 16'($urandom);
		v[0] = t_par;
		write_reg(REG_PARITY_ENABLE, v);
		v = 16'($urandom);
		v[0] = t_even;
		write_reg(REG_PARITY_EVEN, v);
		v = 16'($urandom);
		v[0] = t_linv;
		write_reg(REG_LINE_INVERT, v);
		v = 16'($urandom);
		v[0] = SET_FINV[p];
		write_reg(REG_FLAG_INVERT, v);
		write_reg(REG_SEND_BIT_PERIOD, SET_SP[p]);
		write_reg(REG_RECEIVE_BIT_PERIOD, SET_RP[p]);
		if (p == LAST_SET) write_reg(REG_SPARE, 16'($urandom));
		cfg_ch.valid <= 1'b0;
		rx_on = 1'b0;
	endtask

	// mostly well-formed Q line frames at the receive bit rate, with noise, host bytes and control writes mixed in
	task automatic random_items(int n);
		int          i, roll, slot, r, nd, k;
		logic        lvl, q, pbit;
		logic [7:0]  v;
		for (i = 0; i < n; i++) begin
			roll = $urandom_range(0, 99);
			r = (t_rp == 16'd0) ? 1 : int'(t_rp);
			if (roll == 0) settle();
			if (!rx_on && roll < 7) begin
				v = 8'($urandom);
				nd = t_eight ? 8 : 7;
				pbit = (t_eight ? ^v : ^v[6:0]) ^ ~t_even;
				wave = '1;
				wave[0] = 1'b0;
				for (k = 0; k < nd; k++) wave[k + 1] = v[k];
				if (t_par) wave[nd + 1] = pbit;
				if ($urandom_range(0, 5) == 0) begin
					k = $urandom_range(1, nd + 1);
					wave[k] = ~wave[k];
				end
				rx_len = nd + 2 + (t_par ? 1 : 0);
				rx_on = 1'b1;
				rx_t = 0;
				v = 8'($urandom);
				v[0] = ~t_linv;
				put_item(ACT_QCHG, v, 1'($urandom));
			end else if (roll < 11) begin
				put_item(ACT_HOST, 8'($urandom), 1'($urandom));
			end else if (roll < 14) begin
				case ($urandom_range(0, 2))
					0: v = CTRL_DISABLE;
					1: v = CTRL_ENABLE;
					default: v = 8'($urandom);
				endcase
				put_item(ACT_CTRL, v, 1'($urandom));
			end else if (roll < 16) begin
				put_item(ACT_QCHG, 8'($urandom), 1'($urandom));
			end else begin
				lvl = 1'b1;
				if (rx_on) begin
					rx_t++;
					slot = rx_t / r;
					if (slot < rx_len) lvl = wave[slot];
					else rx_on = 1'b0;
				end
				q = ~lvl ^ t_linv;
				if ($urandom_range(0, 19) == 0) q = ~q;
				put_item(ACT_TICK, 8'($urandom), q);
			end
		end
	endtask

	initial begin
		int stall;
		res_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			stall = idle_on ? $urandom_range(0, 17) : 0;
			if (stall > 0) begin
				res_ch.ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			res_ch.ready <= 1'b1;
			@(posedge clk);
			while (!res_ch.valid) @(posedge clk);
			@(negedge clk);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((item_ch.valid && item_ch.ready) || (res_ch.valid && res_ch.ready) ||
					(cfg_ch.valid && cfg_ch.ready)) begin
				quiet <= 0;
			end else if (quiet >= STALL_LIMIT) begin
				$display("DONE: errors detected");
				$finish;
			end else begin
				quiet <= quiet + 1;
			end
		end
	end

	initial begin
		int p, i;
		arst_n = 1'b0;
		quiet = 0;
		idle_on = 1'b1;
		rx_on = 1'b0;
		item_ch.valid = 1'b0;
		item_ch.action = ACT_TICK;
		item_ch.data = '0;
		item_ch.q_level = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = REG_EIGHT_DATA_BITS;
		cfg_ch.data = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		put_item(ACT_TICK, 8'h00, 1'b1);
		put_item(ACT_CTRL, 8'h41, 1'b0);
		settle();

		load_setting(0);
		put_item(ACT_CTRL, CTRL_DISABLE, 1'b0);
		put_item(ACT_HOST, 8'hff, 1'b1);
		put_item(ACT_TICK, 8'h00, 1'b0);
		put_item(ACT_HOST, 8'h00, 1'b0);
		put_item(ACT_CTRL, 8'h41, 1'b1);
		put_item(ACT_CTRL, CTRL_ENABLE, 1'b0);
		put_item(ACT_TICK, 8'hff, 1'b1);
		put_item(ACT_HOST, 8'ha5, 1'b0);
		put_item(ACT_QCHG, 8'hff, 1'b0);
		put_item(ACT_QCHG, 8'h00, 1'b1);
		for (i = 0; i < 13; i++) put_item(ACT_TICK, 8'h5a, DIRECTED_Q[i]);
		random_items(100);
		settle();

		for (p = 1; p < LAST_SET; p++) begin
			load_setting(p);
			idle_on = (p % 3 != 2);
			random_items(100);
			settle();
		end

		idle_on = 1'b1;
		load_setting(LAST_SET);
		put_item(ACT_HOST, 8'h3c, 1'b0);
		put_item(ACT_QCHG, {7'h55, ~t_linv}, 1'b1);
		for (i = 0; i < 12; i++) put_item(ACT_TICK, 8'h00, 1'($urandom));
		settle();

		if (errors == 0 && outstanding == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

[bit_banged_serial_terminal_link.f]
sv/btl_pkg.sv
sv/btl_if.sv
sv/btl_cfg.sv
sv/btl_tx.sv
sv/btl_rx.sv
sv/bit_banged_serial_terminal_link.sv
tb/btl_link_monitor.sv
tb/tb.sv
